/* rtl/core/salc_pkg.sv */
// Shared types and constants for the set-associative LRU tag cache.
package salc_pkg;

   localparam int MAX_SETS_LOG2_DEF = 6;
   localparam int MAX_WAYS_DEF      = 8;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_STORE  = 2'd1;
   localparam logic [1:0] CMD_MODIFY = 2'd2;

   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_MISS  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_WAYS       = 2'd1;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd2;

   localparam int AGE_W = 8;

   typedef struct packed {
      logic read_set;
      logic update;
      logic clear;
   } cmd_type;

endpackage

/* rtl/core/salc_ram.sv */
// Generic single-port RAM with registered read.
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

/* rtl/core/salc_ctrl.sv */
// Controller: valid clearing after reset, then accept, lookup and update per item.
module salc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic             clear_done,
   output salc_pkg::cmd_type cmd
);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOOK  = 2'd1;
   localparam logic [1:0] ST_OUT   = 2'd2;
   localparam logic [1:0] ST_CLEAR = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       out_free;

   assign out_free   = (state_ff != ST_OUT) || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || (state_ff == ST_OUT && rsp_tready);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign cmd.read_set = req_tvalid && req_tready;
   assign cmd.update   = (state_ff == ST_LOOK);
   assign cmd.clear    = (state_ff == ST_CLEAR);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clear_done) state_in = ST_IDLE;
         ST_IDLE: if (req_tvalid) state_in = ST_LOOK;
         ST_LOOK: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_tready) state_in = req_tvalid ? ST_LOOK : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (!out_free && state_ff == ST_OUT) state_in = ST_OUT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

/* rtl/core/salc_dp.sv */
// Datapath: set storage, tag compare, LRU ranking, counters and result register.
module salc_dp #(
   parameter int MAX_SETS_LOG2 = salc_pkg::MAX_SETS_LOG2_DEF,
   parameter int MAX_WAYS      = salc_pkg::MAX_WAYS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  salc_pkg::cmd_type cmd,
   input  logic [1:0]        command,
   input  logic [63:0]       address,
   input  logic [2:0]        set_index_bits,
   input  logic [3:0]        ways_in_use,
   input  logic [5:0]        block_offset_bits,
   output logic              clear_done,
   output logic [1:0]        outcome,
   output logic              extra_hit,
   output logic [31:0]       total_hits,
   output logic [31:0]       total_misses,
   output logic [31:0]       total_evictions
);
   localparam int SETS  = 1 << MAX_SETS_LOG2;
   localparam int SET_W = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W = $clog2(MAX_WAYS + 1);
   localparam int AW    = salc_pkg::AGE_W;

   logic [63:0]       tag_calc, tag_ff;
   logic [SET_W-1:0]  set_calc, set_ff;
   logic [SET_W-1:0]  clr_ff;
   logic [SET_W-1:0]  ram_addr;
   logic              modify_ff;
   logic [MAX_WAYS-1:0] vrow;
   logic [63:0]       rd_tag [MAX_WAYS];
   logic [AW-1:0]     rd_age [MAX_WAYS];
   logic [MAX_WAYS-1:0] tag_we;
   logic [CNT_W-1:0]  ways;
   logic [5:0]        sb;

   logic [31:0] hits_ff, misses_ff, evicts_ff;
   logic [1:0]  outcome_ff;
   logic        extra_ff;

   always_comb begin
      sb = (32'(set_index_bits) > MAX_SETS_LOG2) ? 6'(MAX_SETS_LOG2) : 6'(set_index_bits);
      if (ways_in_use == 4'd0) ways = CNT_W'(1);
      else if (32'(ways_in_use) > MAX_WAYS) ways = CNT_W'(MAX_WAYS);
      else ways = CNT_W'(ways_in_use);
      tag_calc = (address >> block_offset_bits) << block_offset_bits;
      set_calc = SET_W'((address >> block_offset_bits) & ((64'd1 << sb) - 64'd1));
   end

   assign ram_addr   = cmd.clear ? clr_ff : (cmd.update ? set_ff : set_calc);
   assign clear_done = (clr_ff == SET_W'(SETS - 1));

   // lookup on registered set contents
   logic [MAX_WAYS-1:0] inuse, hitv;
   logic              hit, free_found, evict;
   logic [WAY_W-1:0]  hit_way, free_way, old_way, way_sel;
   logic [AW-1:0]     old_age, limit;
   logic [AW-1:0]     new_age [MAX_WAYS];

   always_comb begin
      hit = 1'b0; hit_way = '0; free_found = 1'b0; free_way = '0;
      old_way = '0; old_age = rd_age[0];
      for (int w = 0; w < MAX_WAYS; w++) begin
         inuse[w] = (w < 32'(ways));
         hitv[w]  = inuse[w] && vrow[w] && (rd_tag[w] == tag_ff);
      end
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hitv[w]) begin hit = 1'b1; hit_way = WAY_W'(w); end
         if (inuse[w] && !vrow[w]) begin free_found = 1'b1; free_way = WAY_W'(w); end
      end
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (inuse[w] && rd_age[w] > old_age) begin old_age = rd_age[w]; old_way = WAY_W'(w); end
      end
      evict = !hit && !free_found;
      way_sel = hit ? hit_way : (free_found ? free_way : old_way);
      limit = hit ? rd_age[hit_way] : old_age;
      for (int w = 0; w < MAX_WAYS; w++) begin
         new_age[w] = rd_age[w];
         if (inuse[w] && vrow[w] && WAY_W'(w) != way_sel) begin
            if ((free_found && !hit) ? (rd_age[w] != '1) : (rd_age[w] < limit))
               new_age[w] = rd_age[w] + AW'(1);
         end
         if (WAY_W'(w) == way_sel) new_age[w] = '0;
         tag_we[w] = cmd.update && !hit && (WAY_W'(w) == way_sel);
      end
   end

   function automatic logic [31:0] sat(input logic [31:0] v, input logic inc);
      sat = (inc && v != 32'hFFFF_FFFF) ? v + 32'd1 : v;
   endfunction

   logic [31:0] h1;
   assign h1 = sat(hits_ff, hit);

   salc_ram #(.WIDTH(MAX_WAYS), .DEPTH(SETS)) u_valid (
      .clock(clock), .wr_en(cmd.update || cmd.clear),
      .addr(ram_addr),
      .wr_data(cmd.clear ? '0 : (vrow | tag_we)), .rd_data(vrow));

   for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
      logic ok;
      assign ok = cmd.update && inuse[w] && (vrow[w] || tag_we[w]);
      salc_ram #(.WIDTH(64), .DEPTH(SETS)) u_tag (
         .clock(clock), .wr_en(tag_we[w]),
         .addr(ram_addr),
         .wr_data(tag_ff), .rd_data(rd_tag[w]));
      salc_ram #(.WIDTH(AW), .DEPTH(SETS)) u_age (
         .clock(clock), .wr_en(ok),
         .addr(ram_addr),
         .wr_data(new_age[w]), .rd_data(rd_age[w]));
   end

   always_ff @(posedge clock) begin
      if (cmd.read_set) begin
         tag_ff    <= tag_calc;
         set_ff    <= set_calc;
         modify_ff <= (command == salc_pkg::CMD_MODIFY);
      end
      if (reset) begin
         clr_ff <= '0;
         hits_ff <= '0; misses_ff <= '0; evicts_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + SET_W'(1);
      end else if (cmd.update) begin
         hits_ff   <= sat(h1, modify_ff);
         misses_ff <= sat(misses_ff, !hit);
         evicts_ff <= sat(evicts_ff, evict);
         outcome_ff <= hit ? salc_pkg::OUT_HIT
                     : (evict ? salc_pkg::OUT_EVICT : salc_pkg::OUT_MISS);
         extra_ff  <= modify_ff;
      end
   end

   assign outcome = outcome_ff;
   assign extra_hit = extra_ff;
   assign total_hits = hits_ff;
   assign total_misses = misses_ff;
   assign total_evictions = evicts_ff;
endmodule

/* rtl/core/set_assoc_lru_cache_sim.sv */
// Top level of the set-associative LRU tag cache.
// After reset the valid bits are cleared one set per cycle, and no item is accepted
// until all 2**MAX_SETS_LOG2 sets (64 with the default parameters) are cleared.
// For each item the indexed set's tags and ages are first read from the per-way
// RAMs, then compared, ranked and written back to the set; the result is
// then held in an output register, and the next item is accepted in the cycle
// its predecessor's result is taken, so no item is accepted while one is in flight.
// Contents survive configuration changes; tags are block-aligned addresses.
module set_assoc_lru_cache_sim #(
   parameter int MAX_SETS_LOG2 = salc_pkg::MAX_SETS_LOG2_DEF,
   parameter int MAX_WAYS      = salc_pkg::MAX_WAYS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,  // address
   input  logic [1:0]   req_tuser,  // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,  // outcome, extra_hit, total_hits, total_misses,
                                    // total_evictions, zero fill
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   salc_pkg::cmd_type cmd;
   logic [2:0] sib_ff;
   logic [3:0] wiu_ff;
   logic [5:0] bob_ff;
   logic [1:0] outcome;
   logic       extra_hit;
   logic       clear_done;
   logic [31:0] th, tm, te;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         sib_ff <= 3'd4; wiu_ff <= 4'd1; bob_ff <= 6'd4;
      end else if (csr_valid) begin
         case (csr_index)
            salc_pkg::CSR_SET_BITS:   sib_ff <= csr_data[2:0];
            salc_pkg::CSR_WAYS:       wiu_ff <= csr_data[3:0];
            salc_pkg::CSR_BLOCK_BITS: bob_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   salc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .clear_done(clear_done),
      .cmd(cmd));

   salc_dp #(.MAX_SETS_LOG2(MAX_SETS_LOG2), .MAX_WAYS(MAX_WAYS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .command(req_tuser), .address(req_tdata),
      .set_index_bits(sib_ff), .ways_in_use(wiu_ff), .block_offset_bits(bob_ff),
      .clear_done(clear_done),
      .outcome(outcome), .extra_hit(extra_hit), .total_hits(th), .total_misses(tm),
      .total_evictions(te));

   assign rsp_tdata = {5'd0, te, tm, th, extra_hit, outcome};
endmodule

/* sim/testbench.sv */
// Self-checking testbench for the set-associative LRU tag cache.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  outcome;
      logic        extra_hit;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evictions;
   } cache_result_type;

   class cache_scoreboard;
      localparam int WAYS = salc_pkg::MAX_WAYS_DEF;
      logic [63:0]   line_tag[512];
      bit            line_valid[512];
      int            line_age[512];
      logic [31:0]   hits, misses, evictions;
      logic [2:0]    set_bits;
      logic [3:0]    ways_cfg;
      logic [5:0]    block_bits;
      cache_result_type pending[$];
      int            errors;

      function new();
         for (int i = 0; i < 512; i++) begin
            line_valid[i] = 0;
            line_age[i] = 0;
         end
         hits = 0; misses = 0; evictions = 0;
         set_bits = 4; ways_cfg = 1; block_bits = 4;
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            salc_pkg::CSR_SET_BITS:   set_bits = val[2:0];
            salc_pkg::CSR_WAYS:       ways_cfg = val[3:0];
            salc_pkg::CSR_BLOCK_BITS: block_bits = val[5:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] bump(logic [31:0] v);
         return (v == 32'hFFFF_FFFF) ? v : v + 1;
      endfunction

      function void promote(int base, int nways, int way, int limit);
         for (int w = 0; w < nways; w++) begin
            if (w != way && line_valid[base + w] && line_age[base + w] < limit &&
                line_age[base + w] < 255)
               line_age[base + w]++;
         end
         line_age[base + way] = 0;
      endfunction

      function logic [1:0] lookup(logic [63:0] addr);
         int          sb, nways, base, victim;
         logic [63:0] blk, tag;
         sb = (set_bits > salc_pkg::MAX_SETS_LOG2_DEF) ? salc_pkg::MAX_SETS_LOG2_DEF
                                                       : set_bits;
         nways = (ways_cfg == 0) ? 1 : (ways_cfg > WAYS) ? WAYS : ways_cfg;
         blk = addr >> block_bits;
         tag = blk << block_bits;
         base = int'(blk & ((64'd1 << sb) - 1)) * WAYS;
         for (int w = 0; w < nways; w++) begin
            if (line_valid[base + w] && line_tag[base + w] == tag) begin
               hits = bump(hits);
               promote(base, nways, w, line_age[base + w]);
               return salc_pkg::OUT_HIT;
            end
         end
         misses = bump(misses);
         for (int w = 0; w < nways; w++) begin
            if (!line_valid[base + w]) begin
               line_valid[base + w] = 1;
               line_tag[base + w] = tag;
               promote(base, nways, w, 256);
               return salc_pkg::OUT_MISS;
            end
         end
         victim = 0;
         for (int w = 1; w < nways; w++)
            if (line_age[base + w] > line_age[base + victim]) victim = w;
         evictions = bump(evictions);
         line_tag[base + victim] = tag;
         promote(base, nways, victim, line_age[base + victim]);
         return salc_pkg::OUT_EVICT;
      endfunction

      function void note_access(logic [1:0] cmd, logic [63:0] addr);
         cache_result_type r;
         r.outcome = lookup(addr);
         r.extra_hit = 0;
         if (cmd == salc_pkg::CMD_MODIFY) begin
            hits = bump(hits);
            r.extra_hit = 1;
         end
         r.hits = hits;
         r.misses = misses;
         r.evictions = evictions;
         pending.push_back(r);
      endfunction

      function void check_result(logic [103:0] d);
         cache_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (d[1:0] !== e.outcome) begin
            $display("%0t: outcome exp %0d got %0d", $time, e.outcome, d[1:0]);
            errors++;
         end
         if (d[2] !== e.extra_hit) begin
            $display("%0t: extra_hit exp %0d got %0d", $time, e.extra_hit, d[2]);
            errors++;
         end
         if (d[34:3] !== e.hits) begin
            $display("%0t: hits exp %0d got %0d", $time, e.hits, d[34:3]);
            errors++;
         end
         if (d[66:35] !== e.misses) begin
            $display("%0t: misses exp %0d got %0d", $time, e.misses, d[66:35]);
            errors++;
         end
         if (d[98:67] !== e.evictions) begin
            $display("%0t: evictions exp %0d got %0d", $time, e.evictions, d[98:67]);
            errors++;
         end
         if (d[103:99] !== 5'd0) begin
            $display("%0t: fill exp 0 got %h", $time, d[103:99]);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [103:0] rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   cache_scoreboard sb = new();
   bit              no_gaps = 0;
   logic [63:0]     block_pool[16];

   set_assoc_lru_cache_sim i_dut (.*);

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);

   function int gap();
      return no_gaps ? 0 : $urandom_range(0, 9);
   endfunction

   initial begin : rsp_side
      int n;
      @(negedge reset);
      forever begin
         n = gap();
         if (n > 0) begin
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_access(logic [1:0] cmd, logic [63:0] addr);
      int n;
      n = gap();
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= addr;
      req_tuser <= cmd;
      do @(posedge clock); while (!req_tready);
      sb.note_access(cmd, addr);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.set_reg(idx, val);
   endtask

   function logic [63:0] pick_address();
      logic [63:0] a;
      a = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) return a;
      return (block_pool[$urandom_range(0, 15)] << sb.block_bits) |
             (a & ((64'd1 << sb.block_bits) - 1));
   endfunction

   function logic [1:0] pick_cmd();
      return $urandom_range(0, 9) == 0 ? CMD_UNUSED : 2'($urandom_range(0, 2));
   endfunction

   initial begin
      logic [2:0] sbits;
      logic [3:0] ways;
      logic [5:0] bbits;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // default settings: direct-mapped, 16 sets, 16-byte blocks
      send_access(salc_pkg::CMD_LOAD,   64'h0);
      send_access(salc_pkg::CMD_LOAD,   64'h8);
      send_access(salc_pkg::CMD_STORE,  64'h100);
      send_access(salc_pkg::CMD_MODIFY, 64'h100);
      send_access(CMD_UNUSED,           64'h104);
      send_access(salc_pkg::CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
      send_access(salc_pkg::CMD_LOAD,   64'hFFFF_FFFF_FFFF_FFF0);
      send_access(salc_pkg::CMD_LOAD,   64'h0);
      // four ways: fill the set, then evict the oldest way on each refill
      write_reg(salc_pkg::CSR_WAYS, 32'd4);
      for (int i = 0; i < 6; i++) send_access(salc_pkg::CMD_LOAD, 64'(i) << 8);
      send_access(salc_pkg::CMD_LOAD, 64'h0);
      // shrink then grow the ways to provoke stale ages
      write_reg(salc_pkg::CSR_WAYS, 32'd0);
      send_access(salc_pkg::CMD_STORE, 64'h2000);
      write_reg(salc_pkg::CSR_WAYS, 32'd15);
      send_access(salc_pkg::CMD_LOAD, 64'h3000);
      write_reg(salc_pkg::CSR_SET_BITS, 32'd7);
      write_reg(salc_pkg::CSR_BLOCK_BITS, 32'd63);
      send_access(salc_pkg::CMD_LOAD, 64'h8000_0000_0000_0000);
      send_access(salc_pkg::CMD_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
      write_reg(salc_pkg::CSR_BLOCK_BITS, 32'd0);
      write_reg(salc_pkg::CSR_SET_BITS, 32'd0);
      send_access(salc_pkg::CMD_LOAD, 64'h5);
      send_access(salc_pkg::CMD_LOAD, 64'h5);

      for (int p = 0; p < 12; p++) begin
         case (p)
            0: begin sbits = 3'd0; ways = 4'd1; bbits = 6'd0; end
            1: begin sbits = 3'd6; ways = 4'd8; bbits = 6'd63; end
            2: begin sbits = 3'd7; ways = 4'd15; bbits = 6'd32; end
            3: begin sbits = 3'd1; ways = 4'd0; bbits = 6'd1; end
            default: begin
               sbits = 3'($urandom_range(0, 7));
               ways = 4'($urandom_range(0, 15));
               bbits = 6'($urandom_range(0, 63));
            end
         endcase
         write_reg(salc_pkg::CSR_SET_BITS, 32'(sbits));
         write_reg(salc_pkg::CSR_WAYS, 32'(ways));
         write_reg(salc_pkg::CSR_BLOCK_BITS, 32'(bbits));
         no_gaps = (p % 3 == 1);
         for (int i = 0; i < 16; i++)
            block_pool[i] = $urandom_range(0, 3) == 0 ? {$urandom, $urandom}
                                                      : 64'($urandom_range(0, 40));
         for (int i = 0; i < 48; i++) begin
            send_access(pick_cmd(), pick_address());
            if (p == 5 && i == 20) drain();
         end
      end
      no_gaps = 0;

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
